// File: rtl/csseq_pkg.sv
`timescale 1ns / 1ps
package csseq_pkg;

  localparam int unsigned CNT_W   = 16;
  localparam int unsigned FAULT_W = 4;
  localparam int unsigned IND_W   = 4;
  localparam int unsigned CFG_IDX_W = 4;
  localparam int unsigned IN_TDATA_W  = 40;
  localparam int unsigned OUT_TDATA_W = 16;

  localparam logic [CNT_W-1:0] DWELL_RST   = 16'd100;
  localparam logic [CNT_W-1:0] DIVIDER_RST = 16'd10;
  localparam logic [CNT_W-1:0] VOUT_RST    = 16'd4000;
  localparam logic [CNT_W-1:0] ILOAD_RST   = 16'd4000;
  localparam logic [CNT_W-1:0] CNT_MAX     = '1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_DWELL   = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DIVIDER = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_VLIMIT  = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ILIMIT  = 4'd3;

  // Fault codes.
  localparam logic [FAULT_W-1:0] FLT_NONE      = 4'd0;
  localparam logic [FAULT_W-1:0] FLT_NO_SOURCE = 4'd1;
  localparam logic [FAULT_W-1:0] FLT_ERROR     = 4'd2;
  localparam logic [FAULT_W-1:0] FLT_IN_OV     = 4'd3;
  localparam logic [FAULT_W-1:0] FLT_OUT_OV    = 4'd4;
  localparam logic [FAULT_W-1:0] FLT_OUT_OC    = 4'd5;

  // Indicator latch bits.
  localparam int unsigned IND_LED1   = 0;
  localparam int unsigned IND_LED2   = 1;
  localparam int unsigned IND_LED3   = 2;
  localparam int unsigned IND_BUZZER = 3;

  typedef enum logic [2:0] {
    MODE_OFF   = 3'd0,
    MODE_CHECK = 3'd1,
    MODE_LOOP  = 3'd2,
    MODE_RESET = 3'd3,
    MODE_ERROR = 3'd4
  } mode_t;

  typedef struct packed {
    mode_t              mode;
    logic [CNT_W-1:0]   dwell_cnt;
    logic [CNT_W-1:0]   sample_cnt;
    logic [FAULT_W-1:0] fault;
    logic               last_done;
    logic               entry;
    logic               pwm;
    logic [IND_W-1:0]   ind;
  } sup_state_t;

  typedef struct packed {
    logic [CNT_W-1:0] dwell_ticks;
    logic [CNT_W-1:0] check_divider;
    logic [CNT_W-1:0] vout_limit;
    logic [CNT_W-1:0] iload_limit;
  } sup_cfg_t;

  typedef struct packed {
    logic [FAULT_W-1:0] protect_fault;
    logic               plugged;
    logic [CNT_W-1:0]   out_voltage;
    logic [CNT_W-1:0]   load_current;
  } sup_item_t;

  typedef struct packed {
    logic mppt_step;
    logic protect_reinit;
  } sup_pulse_t;

  function automatic mode_t next_mode(mode_t m);
    mode_t r;
    unique case (m)
      MODE_OFF:   r = MODE_CHECK;
      MODE_CHECK: r = MODE_LOOP;
      MODE_LOOP:  r = MODE_LOOP;
      MODE_RESET: r = MODE_OFF;
      MODE_ERROR: r = MODE_ERROR;
      default:    r = m;
    endcase
    return r;
  endfunction

  function automatic mode_t back_mode(mode_t m);
    mode_t r;
    unique case (m)
      MODE_OFF:   r = MODE_OFF;
      MODE_CHECK: r = MODE_RESET;
      MODE_LOOP:  r = MODE_RESET;
      MODE_RESET: r = MODE_ERROR;
      MODE_ERROR: r = MODE_ERROR;
      default:    r = m;
    endcase
    return r;
  endfunction

  // Fault code set when a state falls back; none means keep the latch.
  function automatic logic [FAULT_W-1:0] back_code(mode_t m);
    logic [FAULT_W-1:0] r;
    unique case (m)
      MODE_CHECK: r = FLT_NO_SOURCE;
      MODE_RESET: r = FLT_ERROR;
      MODE_ERROR: r = FLT_ERROR;
      default:    r = FLT_NONE;
    endcase
    return r;
  endfunction

endpackage

// File: rtl/csseq_step.sv
`timescale 1ns / 1ps
module csseq_step (
  input  csseq_pkg::sup_state_t cur_i,
  input  csseq_pkg::sup_cfg_t   cfg_i,
  input  csseq_pkg::sup_item_t  item_i,
  output csseq_pkg::sup_state_t nxt_o,
  output csseq_pkg::sup_pulse_t pulse_o
);
  import csseq_pkg::*;

  always_comb begin
    sup_state_t s;
    mode_t      start;
    mode_t      m;
    logic       done;
    logic       mppt;
    logic       reinit;

    s      = cur_i;
    mppt   = 1'b0;
    reinit = 1'b0;
    done   = 1'b1;

    if (s.dwell_cnt != CNT_MAX) s.dwell_cnt = s.dwell_cnt + 1'b1;
    if (s.sample_cnt != CNT_MAX) s.sample_cnt = s.sample_cnt + 1'b1;

    // Periodic protection sample; a new fault forces the reset state.
    if (s.sample_cnt >= cfg_i.check_divider) begin
      s.sample_cnt = '0;
      if (s.mode != MODE_OFF && s.mode != MODE_RESET &&
          item_i.protect_fault != FLT_NONE && s.fault == FLT_NONE) begin
        s.fault     = item_i.protect_fault;
        s.mode      = MODE_RESET;
        s.dwell_cnt = '0;
        s.entry     = 1'b1;
      end
    end

    start = s.mode;
    m     = s.mode;

    if (s.dwell_cnt < cfg_i.dwell_ticks) begin
      unique case (m)
        MODE_OFF: begin
          if (s.entry) begin
            reinit  = 1'b1;
            s.fault = FLT_NONE;
          end
        end
        MODE_CHECK: done = item_i.plugged;
        MODE_LOOP: begin
          if (!item_i.plugged) begin
            done = 1'b0;
          end else if (item_i.out_voltage < cfg_i.vout_limit &&
                       item_i.load_current < cfg_i.iload_limit) begin
            s.ind[IND_LED2] = 1'b1;
            s.ind[IND_LED3] = 1'b0;
            s.pwm           = 1'b1;
            mppt            = 1'b1;
          end else if (item_i.out_voltage > cfg_i.vout_limit) begin
            s.fault = FLT_OUT_OV;
            done    = 1'b0;
          end else if (item_i.load_current > cfg_i.iload_limit) begin
            s.fault = FLT_OUT_OC;
            done    = 1'b0;
          end
        end
        MODE_RESET, MODE_ERROR: begin
          if (s.entry) s.pwm = 1'b0;
          if (s.fault == FLT_IN_OV) begin
            s.ind[IND_LED1] = 1'b0;
          end else if (s.fault == FLT_OUT_OV) begin
            s.ind[IND_LED1] = 1'b1;
            s.ind[IND_LED2] = 1'b0;
            s.ind[IND_LED3] = 1'b1;
          end else if (s.fault == FLT_OUT_OC) begin
            s.ind[IND_LED1]   = 1'b0;
            s.ind[IND_LED2]   = 1'b1;
            s.ind[IND_LED3]   = 1'b1;
            s.ind[IND_BUZZER] = 1'b1;
          end
          done = (m == MODE_RESET);
        end
        default: done = 1'b1;
      endcase
      s.entry     = 1'b0;
      s.last_done = done;
      // A failing action falls back at once, except in the error state.
      if (m != MODE_ERROR && !done) begin
        s.mode      = back_mode(m);
        s.dwell_cnt = '0;
        if (back_code(m) != FLT_NONE) s.fault = back_code(m);
      end
    end else begin
      s.dwell_cnt = '0;
      if (s.last_done) begin
        s.mode = next_mode(m);
      end else begin
        s.mode = back_mode(m);
        if (back_code(m) != FLT_NONE) s.fault = back_code(m);
      end
    end

    if (s.mode != start) begin
      s.dwell_cnt = '0;
      s.entry     = 1'b1;
    end

    nxt_o                  = s;
    pulse_o.mppt_step      = mppt;
    pulse_o.protect_reinit = reinit;
  end

endmodule

// File: rtl/converter_supervisor_sequencer_core.sv
`timescale 1ns / 1ps
// A result is registered and appears on out_tvalid in the cycle after its tick request is accepted.
// Throughput: one tick per cycle; the supervisor state and the result register are both
// updated in the single accept cycle, and input is taken while the output is free or taken.
// Reset (rst_n low, synchronous): state off, counters and latches cleared, entry flag set,
// configuration back to dwell 100, divider 10, limits 4000; no result pending.
module converter_supervisor_sequencer_core (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_tvalid,
  output logic                                    in_tready,
  // [3:0] protect_fault, [4] plugged, [20:5] out_voltage, [36:21] load_current, rest zero
  input  logic [csseq_pkg::IN_TDATA_W-1:0]        in_tdata,
  output logic                                    out_tvalid,
  input  logic                                    out_tready,
  // [2:0] cur_state, [6:3] fault, [7] pwm_on, [8] mppt_step, [9] protect_reinit,
  // [10] led_one, [11] led_two, [12] led_three, [13] buzzer, [15:14] zero
  output logic [csseq_pkg::OUT_TDATA_W-1:0]       out_tdata,
  input  logic                                    cfg_valid,
  output logic                                    cfg_ready,
  input  logic [csseq_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [csseq_pkg::CNT_W-1:0]             cfg_data
);
  import csseq_pkg::*;

  sup_cfg_t   cfg_r;
  sup_state_t state_r;
  sup_state_t state_nxt;
  sup_item_t  item;
  sup_pulse_t pulse;
  logic       out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r;
  logic [OUT_TDATA_W-1:0] out_data_nxt;
  logic       in_accept;

  assign cfg_ready  = 1'b1;
  assign in_tready  = !out_valid_r || out_tready;
  assign in_accept  = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign item.protect_fault = in_tdata[3:0];
  assign item.plugged       = in_tdata[4];
  assign item.out_voltage   = in_tdata[20:5];
  assign item.load_current  = in_tdata[36:21];

  csseq_step u_step (
    .cur_i   (state_r),
    .cfg_i   (cfg_r),
    .item_i  (item),
    .nxt_o   (state_nxt),
    .pulse_o (pulse)
  );

  assign out_data_nxt = {2'b00,
                         state_nxt.ind[IND_BUZZER],
                         state_nxt.ind[IND_LED3],
                         state_nxt.ind[IND_LED2],
                         state_nxt.ind[IND_LED1],
                         pulse.protect_reinit,
                         pulse.mppt_step,
                         state_nxt.pwm,
                         state_nxt.fault,
                         state_nxt.mode};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.dwell_ticks   <= DWELL_RST;
      cfg_r.check_divider <= DIVIDER_RST;
      cfg_r.vout_limit    <= VOUT_RST;
      cfg_r.iload_limit   <= ILOAD_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_DWELL:   cfg_r.dwell_ticks   <= cfg_data;
        REG_DIVIDER: cfg_r.check_divider <= cfg_data;
        REG_VLIMIT:  cfg_r.vout_limit    <= cfg_data;
        REG_ILIMIT:  cfg_r.iload_limit   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.mode       <= MODE_OFF;
      state_r.dwell_cnt  <= '0;
      state_r.sample_cnt <= '0;
      state_r.fault      <= FLT_NONE;
      state_r.last_done  <= 1'b0;
      state_r.entry      <= 1'b1;
      state_r.pwm        <= 1'b0;
      state_r.ind        <= '0;
      out_valid_r        <= 1'b0;
    end else begin
      if (in_accept) begin
        state_r     <= state_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_data_r <= out_data_nxt;
    end
  end

`ifndef SYNTH
  // The off action's reinit pulse only comes with off held and the fault cleared.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r[9] |->
      out_data_r[2:0] == MODE_OFF && out_data_r[6:3] == FLT_NONE)
    else $error("protect_reinit outside the off state");

  // An MPPT step is only requested from closed loop with the PWM running.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r[8] |->
      out_data_r[2:0] == MODE_LOOP && out_data_r[7] && out_data_r[11] && !out_data_r[12])
    else $error("mppt_step without closed loop and PWM");

  // A result that is not taken stays on the output unchanged.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_tready |=> out_valid_r && $stable(out_data_r))
    else $error("pending result dropped or changed");

  // The buzzer latch never clears outside reset.
  assert property (@(posedge clk) disable iff (!rst_n)
    state_r.ind[IND_BUZZER] |=> state_r.ind[IND_BUZZER])
    else $error("buzzer latch cleared");
`endif

endmodule
